>>> hdl/a2b_pkg.sv
// ----------------------------------------------------------------------------
// a2b_pkg
// Shared types and constants of the length-prefix to start-code converter.
// ----------------------------------------------------------------------------
`default_nettype none

package a2b_pkg;

    localparam int CHUNK_SIZE_BITS_DEF = 24;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // chunk layout
    localparam int MIN_CHUNK_BYTES  = 4;
    localparam int MIN_HEADER_BYTES = 10;
    localparam int VID_PREFIX_END   = 3;
    localparam int HDR_LEN_SIZE_POS = 8;
    localparam int HDR_SPS_CNT_POS  = 9;
    localparam int HDR_LEN_SIZE     = 2;
    localparam int VID_LEN_SIZE_ALT = 4;

    localparam logic [7:0] LEN_SIZE_MASK = 8'h03;
    localparam logic [7:0] SPS_CNT_MASK  = 8'h1F;

    // start code 00 00 00 01
    localparam int         START_CODE_LEN  = 4;
    localparam logic [7:0] START_CODE_ZERO = 8'h00;
    localparam logic [7:0] START_CODE_ONE  = 8'h01;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_NEXT,
        PH_LEN,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic {
        ACT_START,
        ACT_BYTE
    } act_kind_t;

    // one queued action: a whole start code or one payload byte
    typedef struct packed {
        act_kind_t  kind;
        logic [7:0] data;
        logic       last;
    } act_t;

endpackage

`default_nettype wire

>>> hdl/a2b_parse.sv
// ----------------------------------------------------------------------------
// a2b_parse
// Front end: walks each chunk byte by byte and issues start-code and payload
// actions.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_parse
    import a2b_pkg::*;
#(
    parameter int CHUNK_SIZE_BITS = CHUNK_SIZE_BITS_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       chunk_first,
    input  wire logic [CHUNK_SIZE_BITS-1:0] chunk_size,
    input  wire logic                       write_header,
    output      logic                       act_valid,
    output      act_t                       act
);

    localparam int SUM_W = 34;

    phase_t                     phase_reg, phase_next;
    logic [CHUNK_SIZE_BITS-1:0] pos_reg, pos_next;
    logic [2:0]                 len_size_reg, len_size_next;
    logic                       hdr_reg, hdr_next;
    logic [4:0]                 sps_reg, sps_next;
    logic [7:0]                 pps_reg, pps_next;
    logic                       pps_unread_reg, pps_unread_next;
    logic [31:0]                acc_reg, acc_next;
    logic [2:0]                 seen_reg, seen_next;
    logic [31:0]                rem_reg, rem_next;

    logic [CHUNK_SIZE_BITS-1:0] left;
    logic [2:0]                 need;
    logic [31:0]                acc_sh;
    logic [2:0]                 seen_inc;
    logic [31:0]                rem_dec;
    logic [SUM_W-1:0]           unit_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pos_reg        <= '0;
            len_size_reg   <= 3'(VID_LEN_SIZE_ALT);
            hdr_reg        <= 1'b0;
            sps_reg        <= '0;
            pps_reg        <= '0;
            pps_unread_reg <= 1'b1;
            acc_reg        <= '0;
            seen_reg       <= '0;
            rem_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            len_size_reg   <= len_size_next;
            hdr_reg        <= hdr_next;
            sps_reg        <= sps_next;
            pps_reg        <= pps_next;
            pps_unread_reg <= pps_unread_next;
            acc_reg        <= acc_next;
            seen_reg       <= seen_next;
            rem_reg        <= rem_next;
        end
    end

    assign left     = chunk_size - pos_reg;
    assign need     = hdr_reg ? 3'(HDR_LEN_SIZE) : len_size_reg;
    assign acc_sh   = {acc_reg[23:0], in_byte};
    assign seen_inc = seen_reg + 3'd1;
    assign rem_dec  = rem_reg - 32'd1;
    assign unit_end = SUM_W'(pos_reg) + SUM_W'(1) + SUM_W'(acc_sh);

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        len_size_next   = len_size_reg;
        hdr_next        = hdr_reg;
        sps_next        = sps_reg;
        pps_next        = pps_reg;
        pps_unread_next = pps_unread_reg;
        acc_next        = acc_reg;
        seen_next       = seen_reg;
        rem_next        = rem_reg;
        act_valid       = 1'b0;
        act.kind        = ACT_BYTE;
        act.data        = in_byte;
        act.last        = 1'b0;

        if (step)
        begin
            if (chunk_first)
            begin
                pos_next   = CHUNK_SIZE_BITS'(1);
                phase_next = PH_IDLE;
                if (chunk_size >= CHUNK_SIZE_BITS'(MIN_CHUNK_BYTES))
                begin
                    if (in_byte == 8'h00)
                    begin
                        if (chunk_size >= CHUNK_SIZE_BITS'(MIN_HEADER_BYTES))
                        begin
                            hdr_next   = 1'b1;
                            phase_next = PH_PRE;
                        end
                    end
                    else
                    begin
                        hdr_next   = 1'b0;
                        phase_next = PH_PRE;
                        if (len_size_reg != 3'(HDR_LEN_SIZE))
                            len_size_next = 3'(VID_LEN_SIZE_ALT);
                    end
                end
            end
            else
            begin
                // saturate position at its maximum
                if (pos_reg != '1)
                    pos_next = pos_reg + CHUNK_SIZE_BITS'(1);

                if (phase_reg != PH_IDLE && pos_reg >= chunk_size)
                begin
                    phase_next = PH_IDLE;
                end
                else
                begin
                    unique case (phase_reg)
                        PH_PRE:
                        begin
                            if (hdr_reg)
                            begin
                                if (pos_reg == CHUNK_SIZE_BITS'(HDR_LEN_SIZE_POS))
                                begin
                                    len_size_next = 3'(in_byte & LEN_SIZE_MASK) + 3'd1;
                                    if (!write_header)
                                        phase_next = PH_IDLE;
                                end
                                else if (pos_reg == CHUNK_SIZE_BITS'(HDR_SPS_CNT_POS))
                                begin
                                    sps_next        = 5'(in_byte & SPS_CNT_MASK);
                                    pps_unread_next = 1'b1;
                                    phase_next      = PH_NEXT;
                                end
                            end
                            else if (pos_reg == CHUNK_SIZE_BITS'(VID_PREFIX_END))
                            begin
                                phase_next = PH_NEXT;
                            end
                        end
                        PH_NEXT:
                        begin
                            if (left < CHUNK_SIZE_BITS'(need))
                            begin
                                phase_next = PH_IDLE;
                            end
                            else if (hdr_reg && sps_reg == '0 && pps_unread_reg)
                            begin
                                // PPS count byte
                                pps_next        = in_byte;
                                pps_unread_next = 1'b0;
                            end
                            else if (hdr_reg && sps_reg == '0
                                     && (pps_reg == '0 || pps_unread_reg))
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                if (hdr_reg)
                                begin
                                    if (sps_reg != '0)
                                        sps_next = sps_reg - 5'd1;
                                    else
                                        pps_next = pps_reg - 8'd1;
                                end
                                acc_next   = 32'(in_byte);
                                seen_next  = 3'd1;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            acc_next  = acc_sh;
                            seen_next = seen_inc;
                            if (seen_inc >= need)
                            begin
                                if (unit_end > SUM_W'(chunk_size))
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    act_valid = 1'b1;
                                    act.kind  = ACT_START;
                                    act.last  = (acc_sh == '0);
                                    rem_next  = acc_sh;
                                    phase_next = (acc_sh == '0) ? PH_NEXT : PH_PAYLOAD;
                                end
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            rem_next  = rem_dec;
                            act_valid = 1'b1;
                            act.last  = (rem_dec == '0);
                            if (rem_dec == '0)
                                phase_next = PH_NEXT;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/a2b_queue.sv
// ----------------------------------------------------------------------------
// a2b_queue
// Small action queue between the parser and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_queue
    import a2b_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire act_t wr_data,
    output      logic full,
    output      logic rd_valid,
    input  wire logic rd_en,
    output      act_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    act_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

>>> hdl/a2b_emit.sv
// ----------------------------------------------------------------------------
// a2b_emit
// Back end: expands queued actions into output words and holds the current
// word until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_emit
    import a2b_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire act_t       q_data,
    output      logic       q_pop,
    output      logic       empty,
    input  wire logic       pop,
    output      logic [7:0] out_byte,
    output      logic       unit_first,
    output      logic       unit_last
);

    localparam logic [1:0] BEAT_LAST = 2'(START_CODE_LEN - 1);

    logic       valid_reg, valid_next;
    act_t       cur_reg, cur_next;
    logic [1:0] beat_reg, beat_next;
    logic       taken, done, is_start;

    assign is_start = (cur_reg.kind == ACT_START);
    assign taken    = pop && valid_reg;
    assign done     = !is_start || (beat_reg == BEAT_LAST);
    assign q_pop    = q_valid && (!valid_reg || (taken && done));

    always_comb
    begin
        valid_next = valid_reg;
        cur_next   = cur_reg;
        beat_next  = beat_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
            cur_next   = q_data;
            beat_next  = '0;
        end
        else if (taken)
        begin
            if (done)
                valid_next = 1'b0;
            else
                beat_next = beat_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    assign empty = !valid_reg;

    always_comb
    begin
        if (is_start)
        begin
            out_byte   = (beat_reg == BEAT_LAST) ? START_CODE_ONE : START_CODE_ZERO;
            unit_first = (beat_reg == '0);
            unit_last  = (beat_reg == BEAT_LAST) && cur_reg.last;
        end
        else
        begin
            out_byte   = cur_reg.data;
            unit_first = 1'b0;
            unit_last  = cur_reg.last;
        end
    end

endmodule

`default_nettype wire

>>> hdl/avcc_to_annexb_converter.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// Converts length-prefixed H.264 chunk bytes into a start-code framed stream.
// ----------------------------------------------------------------------------
//  side    | handshake         | words
//  --------+-------------------+-----------------------------------------------
//  input   | push / full       | in_byte, chunk_first, chunk_size, write_header
//  output  | empty / pop       | out_byte, unit_first, unit_last
//
//  One input word is taken per cycle while full is low; the parser handles it in that cycle.
//  A payload byte gives one output word, a unit start gives four (00 00 00 01),
//  so output runs at one word per cycle while pop is high and the action queue absorbs bursts.
//  A taken word goes into the action queue, then into the emitter's word register once it is free.
//  full rises when the action queue fills, after a stalled output or start codes.
//  Reset puts the parser in idle, so bytes up to the next chunk start are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module avcc_to_annexb_converter
    import a2b_pkg::*;
#(
    parameter int CHUNK_SIZE_BITS = CHUNK_SIZE_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output      logic                       full,
    input  wire logic [7:0]                 in_byte,
    input  wire logic                       chunk_first,
    input  wire logic [CHUNK_SIZE_BITS-1:0] chunk_size,
    input  wire logic                       write_header,
    output      logic                       empty,
    input  wire logic                       pop,
    output      logic [7:0]                 out_byte,
    output      logic                       unit_first,
    output      logic                       unit_last
);

    logic act_valid;
    act_t act;
    logic q_full, q_valid, q_pop;
    act_t q_data;

    assign full = q_full;

    a2b_parse #(
        .CHUNK_SIZE_BITS(CHUNK_SIZE_BITS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (push && !q_full),
        .in_byte     (in_byte),
        .chunk_first (chunk_first),
        .chunk_size  (chunk_size),
        .write_header(write_header),
        .act_valid   (act_valid),
        .act         (act)
    );

    a2b_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (act_valid),
        .wr_data (act),
        .full    (q_full),
        .rd_valid(q_valid),
        .rd_en   (q_pop),
        .rd_data (q_data)
    );

    a2b_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .unit_first(unit_first),
        .unit_last (unit_last)
    );

endmodule

`default_nettype wire

>>> hdl/a2b_checker.sv
// ----------------------------------------------------------------------------
// a2b_checker
// Port-level checks on the output stream of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module a2b_checker
    import a2b_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] out_byte,
    input wire logic       unit_first,
    input wire logic       unit_last
);

    // a unit opens on a zero start-code byte
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && unit_first) |-> (out_byte == START_CODE_ZERO))
        else $error("unit start word is not zero");

    // even an empty unit ends on its last start-code byte, never on the first
    a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(unit_first && unit_last))
        else $error("unit_first and unit_last on the same word");

    // the rest of a start code follows at once
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && unit_first) |=>
            (!empty && out_byte == START_CODE_ZERO && !unit_first && !unit_last))
        else $error("start code broken after first word");

    // hold the word while it is not popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(out_byte) && $stable(unit_first) && $stable(unit_last)))
        else $error("output word changed while stalled");

endmodule

bind avcc_to_annexb_converter a2b_checker u_a2b_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .unit_first(unit_first),
    .unit_last (unit_last)
);

`default_nettype wire

>>> tb/avcc_to_annexb_converter_test.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_test
// Streams length-prefixed H.264 chunks through the converter and checks every
// start-code framed output word against a cycle-free prediction of the parser.
// Stimulus mixes header chunks, video chunks, truncated and oversized chunks
// and loose noise; both handshake sides idle at random.
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter_test
    import a2b_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         SZW           = CHUNK_SIZE_BITS_DEF;
    localparam logic [8:0] PPS_UNREAD    = 9'h100;
    localparam int         RANDOM_ITEMS  = 180;
    localparam int         IDLE_LIMIT    = 4000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0]     data;
        logic           first;
        logic [SZW-1:0] size;
        logic           wh;
    } chunk_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       head;
        logic       tail;
    } stream_word_t;

    logic           clk          = 1'b0;
    logic           rst_n        = 1'b0;
    logic           push         = 1'b0;
    logic           full;
    logic [7:0]     in_byte      = 8'h00;
    logic           chunk_first  = 1'b0;
    logic [SZW-1:0] chunk_size   = '0;
    logic           write_header = 1'b0;
    logic           empty;
    logic           pop          = 1'b0;
    logic [7:0]     out_byte;
    logic           unit_first;
    logic           unit_last;

    avcc_to_annexb_converter #(
        .CHUNK_SIZE_BITS(SZW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .chunk_first (chunk_first),
        .chunk_size  (chunk_size),
        .write_header(write_header),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .unit_first  (unit_first),
        .unit_last   (unit_last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    chunk_word_t  chunk_bytes_q[$];
    stream_word_t framed_q[$];
    logic [7:0]   body_q[$];

    int total_items    = 0;
    int accepted_items = 0;
    int words_seen     = 0;
    int fail_count     = 0;
    int gen_len_size   = 4;
    int drv_gap        = 0;
    int drv_run        = 0;
    int mon_gap        = 0;
    int mon_run        = 0;
    int stall_cycles   = 0;
    stream_word_t want_word;

    // ------------------------------------------------------------------
    // parser prediction
    // ------------------------------------------------------------------
    logic [2:0]     fr_len_size;
    logic [SZW-1:0] fr_pos;
    phase_t         fr_phase;
    logic [4:0]     fr_sps_left;
    logic [8:0]     fr_pps_left;
    logic [31:0]    fr_len_acc;
    logic [2:0]     fr_len_cnt;
    logic [31:0]    fr_pay_left;
    logic           fr_in_hdr;

    function automatic void clear_framer();
        fr_len_size = 3'd4;
        fr_pos      = '0;
        fr_phase    = PH_IDLE;
        fr_sps_left = '0;
        fr_pps_left = PPS_UNREAD;
        fr_len_acc  = '0;
        fr_len_cnt  = '0;
        fr_pay_left = '0;
        fr_in_hdr   = 1'b0;
    endfunction

    function automatic void expect_word(input logic [7:0] data, input logic head,
                                        input logic tail);
        stream_word_t w;
        w.data = data;
        w.head = head;
        w.tail = tail;
        framed_q.push_back(w);
    endfunction

    function automatic void frame_chunk_byte(input logic [7:0] b, input logic first,
                                             input logic [SZW-1:0] size, input logic wh);
        logic [SZW-1:0] p;
        int             need;
        logic           open_unit;
        if (first)
        begin
            fr_phase = PH_IDLE;
            if (size >= MIN_CHUNK_BYTES)
            begin
                if (b == 8'h00)
                begin
                    if (size >= MIN_HEADER_BYTES)
                    begin
                        fr_in_hdr = 1'b1;
                        fr_phase  = PH_PRE;
                    end
                end
                else
                begin
                    fr_in_hdr = 1'b0;
                    if (fr_len_size != HDR_LEN_SIZE)
                        fr_len_size = 3'(VID_LEN_SIZE_ALT);
                    fr_phase = PH_PRE;
                end
            end
            fr_pos = SZW'(1);
        end
        else
        begin
            p = fr_pos;
            if (p != {SZW{1'b1}})
                fr_pos = p + 1'b1;
            need = fr_in_hdr ? HDR_LEN_SIZE : int'(fr_len_size);
            if (fr_phase != PH_IDLE && p >= size)
                fr_phase = PH_IDLE;
            else
            begin
                case (fr_phase)
                    PH_PRE:
                    begin
                        if (fr_in_hdr)
                        begin
                            if (p == HDR_LEN_SIZE_POS)
                            begin
                                fr_len_size = 3'(b & LEN_SIZE_MASK) + 3'd1;
                                if (!wh)
                                    fr_phase = PH_IDLE;
                            end
                            else if (p == HDR_SPS_CNT_POS)
                            begin
                                fr_sps_left = 5'(b & SPS_CNT_MASK);
                                fr_pps_left = PPS_UNREAD;
                                fr_phase    = PH_NEXT;
                            end
                        end
                        else if (p == VID_PREFIX_END)
                            fr_phase = PH_NEXT;
                    end
                    PH_NEXT:
                    begin
                        if ((32'(size) - 32'(p)) < 32'(need))
                            fr_phase = PH_IDLE;
                        else if (fr_in_hdr && fr_sps_left == 0 && fr_pps_left == PPS_UNREAD)
                            fr_pps_left = {1'b0, b};
                        else
                        begin
                            open_unit = 1'b1;
                            if (fr_in_hdr)
                            begin
                                if (fr_sps_left != 0)
                                    fr_sps_left = fr_sps_left - 1'b1;
                                else if (fr_pps_left != 0)
                                    fr_pps_left = fr_pps_left - 1'b1;
                                else
                                begin
                                    // both counts used up: drop the rest of the chunk
                                    open_unit = 1'b0;
                                    fr_phase  = PH_IDLE;
                                end
                            end
                            if (open_unit)
                            begin
                                fr_len_acc = {24'h0, b};
                                fr_len_cnt = 3'd1;
                                fr_phase   = PH_LEN;
                            end
                        end
                    end
                    PH_LEN:
                    begin
                        fr_len_acc = {fr_len_acc[23:0], b};
                        fr_len_cnt = fr_len_cnt + 1'b1;
                        if (int'(fr_len_cnt) >= need)
                        begin
                            if (64'(p) + 64'd1 + 64'(fr_len_acc) > 64'(size))
                                fr_phase = PH_IDLE;
                            else
                            begin
                                expect_word(START_CODE_ZERO, 1'b1, 1'b0);
                                expect_word(START_CODE_ZERO, 1'b0, 1'b0);
                                expect_word(START_CODE_ZERO, 1'b0, 1'b0);
                                expect_word(START_CODE_ONE, 1'b0, fr_len_acc == 0);
                                if (fr_len_acc == 0)
                                    fr_phase = PH_NEXT;
                                else
                                begin
                                    fr_pay_left = fr_len_acc;
                                    fr_phase    = PH_PAYLOAD;
                                end
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        fr_pay_left = fr_pay_left - 1'b1;
                        expect_word(b, 1'b0, fr_pay_left == 0);
                        if (fr_pay_left == 0)
                            fr_phase = PH_NEXT;
                    end
                    default:
                        fr_phase = PH_IDLE;
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic add_word(input logic [7:0] data, input logic first,
                            input logic [SZW-1:0] size, input logic wh);
        chunk_word_t w;
        w.data  = data;
        w.first = first;
        w.size  = size;
        w.wh    = wh;
        chunk_bytes_q.push_back(w);
    endtask

    // send the built chunk; from word cut on, chunk_size reads size2
    task automatic emit_chunk(input logic [SZW-1:0] size, input int sent, input logic wh,
                              input int cut, input logic [SZW-1:0] size2);
        if (body_q.size() != 0 && body_q[0] == 8'h00 && size >= MIN_HEADER_BYTES
            && sent > HDR_LEN_SIZE_POS)
            gen_len_size = int'(body_q[HDR_LEN_SIZE_POS][1:0]) + 1;
        for (int i = 0; i < sent && i < body_q.size(); i++)
            add_word(body_q[i], i == 0, (i >= cut) ? size2 : size, wh);
        body_q.delete();
    endtask

    task automatic load_bytes(input logic [255:0] bytes, input int n);
        for (int i = 0; i < n; i++)
            body_q.push_back(bytes[8*(n-1-i) +: 8]);
    endtask

    task automatic put_len(input logic [31:0] len, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            body_q.push_back(len[8*i +: 8]);
    endtask

    task automatic put_payload(input logic [31:0] len);
        int n;
        n = (len > 8) ? $urandom_range(0, 3) : int'(len);
        repeat (n) body_q.push_back(8'($urandom()));
    endtask

    function automatic logic [31:0] pick_unit_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 32'd0;
        else if (roll < 88)
            return 32'($urandom_range(1, 6));
        return 32'($urandom());
    endfunction

    task automatic finish_chunk(input logic wh);
        int             n;
        int             sent;
        int             cut;
        int unsigned    roll;
        logic [SZW-1:0] size;
        logic [SZW-1:0] size2;
        n    = body_q.size();
        size = SZW'(n);
        sent = n;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            size = SZW'(n - $urandom_range(1, 3));
        else if (roll < 22)
        begin
            // declared longer than sent: the next chunk start abandons it
            size = (roll < 15) ? {SZW{1'b1}} : SZW'(n + $urandom_range(1, 40));
            sent = $urandom_range(1, n);
        end
        else if (roll < 30)
        begin
            repeat ($urandom_range(1, 3)) body_q.push_back(8'($urandom()));
            sent = body_q.size();
        end
        cut   = sent;
        size2 = size;
        if ($urandom_range(0, 19) == 0)
        begin
            cut   = $urandom_range(1, sent);
            size2 = SZW'($urandom_range(0, 40));
        end
        emit_chunk(size, sent, wh, cut, size2);
    endtask

    task automatic build_video();
        int          ls;
        logic [31:0] len;
        ls = (gen_len_size == HDR_LEN_SIZE) ? HDR_LEN_SIZE : VID_LEN_SIZE_ALT;
        body_q.push_back(8'($urandom_range(1, 255)));
        repeat (3) body_q.push_back(8'($urandom()));
        repeat ($urandom_range(1, 3))
        begin
            len = pick_unit_len();
            put_len(len, ls);
            put_payload(len);
        end
        finish_chunk(1'($urandom()));
    endtask

    task automatic add_header_unit();
        logic [31:0] len;
        if ($urandom_range(0, 9) == 0)
            len = {16'h0, 16'($urandom())};
        else
            len = 32'($urandom_range(0, 4));
        put_len(len, HDR_LEN_SIZE);
        put_payload(len);
    endtask

    task automatic build_header();
        int         sps;
        int         pps;
        logic [1:0] code;
        body_q.push_back(8'h00);
        repeat (7) body_q.push_back(8'($urandom()));
        if ($urandom_range(0, 4) == 0)
            code = 2'($urandom());
        else
            code = $urandom_range(0, 1) ? 2'b01 : 2'b11;
        body_q.push_back({6'($urandom()), code});
        sps = ($urandom_range(0, 9) == 0) ? 31 : $urandom_range(0, 2);
        body_q.push_back({3'($urandom()), 5'(sps)});
        repeat ((sps > 2) ? 2 : sps) add_header_unit();
        pps = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255) : $urandom_range(0, 2);
        body_q.push_back(8'(pps));
        repeat ((pps > 2) ? 2 : pps) add_header_unit();
        if ($urandom_range(0, 3) == 0)
            repeat (2) body_q.push_back(8'($urandom()));
        finish_chunk($urandom_range(0, 4) != 0);
    endtask

    task automatic build_noise();
        int             n;
        int unsigned    roll;
        logic [SZW-1:0] size;
        n = $urandom_range(1, 12);
        repeat (n) body_q.push_back(8'($urandom()));
        if ($urandom_range(0, 3) == 0)
            body_q[0] = 8'h00;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            size = SZW'($urandom_range(0, 3));
        else if (roll < 80)
            size = SZW'($urandom_range(4, 9));
        else
            size = SZW'($urandom());
        emit_chunk(size, n, 1'($urandom()), n, size);
    endtask

    task automatic build_loose();
        repeat ($urandom_range(1, 3))
            add_word(8'($urandom()), 1'b0, SZW'($urandom()), 1'($urandom()));
    endtask

    task automatic next_gap(inout int run, output int gap);
        if (run > 0)
        begin
            run = run - 1;
            gap = 0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            run = $urandom_range(10, 40);
            gap = 0;
        end
        else
            gap = $urandom_range(0, 10);
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push         <= 1'b0;
            in_byte      <= 8'h00;
            chunk_first  <= 1'b0;
            chunk_size   <= '0;
            write_header <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                frame_chunk_byte(in_byte, chunk_first, chunk_size, write_header);
                accepted_items = accepted_items + 1;
            end
            if (!push || !full)
            begin
                if (drv_gap != 0)
                begin
                    drv_gap = drv_gap - 1;
                    push <= 1'b0;
                end
                else if (chunk_bytes_q.size() != 0)
                begin
                    in_byte      <= chunk_bytes_q[0].data;
                    chunk_first  <= chunk_bytes_q[0].first;
                    chunk_size   <= chunk_bytes_q[0].size;
                    write_header <= chunk_bytes_q[0].wh;
                    void'(chunk_bytes_q.pop_front());
                    push <= 1'b1;
                    next_gap(drv_run, drv_gap);
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (framed_q.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("word %0d: none expected, got %h first=%b last=%b",
                                 words_seen, out_byte, unit_first, unit_last);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want_word = framed_q.pop_front();
                    if (out_byte !== want_word.data || unit_first !== want_word.head
                        || unit_last !== want_word.tail)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display("word %0d: expected %h first=%b last=%b, got %h first=%b last=%b",
                                     words_seen, want_word.data, want_word.head,
                                     want_word.tail, out_byte, unit_first, unit_last);
                        fail_count = fail_count + 1;
                    end
                end
                words_seen = words_seen + 1;
                next_gap(mon_run, mon_gap);
            end
            if (mon_gap != 0)
            begin
                mon_gap = mon_gap - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // end the run when neither side has moved a word for too long
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else if (stall_cycles == IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        int directed_items;
        int unsigned roll;
        clear_framer();

        // bytes before any chunk start
        add_word(8'hFF, 1'b0, {SZW{1'b1}}, 1'b1);
        add_word(8'h00, 1'b0, '0, 1'b0);
        // header: 2-byte lengths, one SPS of one byte, one empty PPS
        load_bytes(256'h0011223344556677_FD_E1_0001_AA_01_0000, 16);
        emit_chunk(SZW'(16), 16, 1'b1, 16, SZW'(16));
        // video unit of one byte, then one byte past the chunk end
        load_bytes(256'hFF000000_0001_80_5A, 8);
        emit_chunk(SZW'(7), 8, 1'b0, 8, SZW'(7));
        gen_len_size   = HDR_LEN_SIZE;
        directed_items = chunk_bytes_q.size();

        while (chunk_bytes_q.size() < directed_items + RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                build_video();
            else if (roll < 70)
                build_header();
            else if (roll < 90)
                build_noise();
            else
                build_loose();
        end
        // close with a clean chunk start so a truncated last chunk is still cut
        add_word(8'h00, 1'b1, '0, 1'b0);
        total_items = chunk_bytes_q.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_items != total_items)
            @(posedge clk);
        while (framed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (framed_q.size() != 0)
            fail_count = fail_count + 1;

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
